>>> sv/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only out of reset.
`define LRSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define LRSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRSS_ASSERT(lbl, prop, msg)
`define LRSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/lrss_pkg.sv
// Types and constants of the limit-reversing stepper sequencer.
`timescale 1ns / 1ps
package lrss_pkg;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_RUN    = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_DUTY   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_RUN      = 2'd1,
    MODE_TO_LIMIT = 2'd2,
    MODE_BACK     = 2'd3
  } mode_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_RUN = 1'b1;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [15:0] EXTRA_RUN_RST = 16'd2000;

  typedef struct packed {
    logic [1:0]  command;
    logic        switch_level;
    logic [31:0] now_ms;
    logic [7:0]  duty_value;
  } in_item_t;

  typedef struct packed {
    logic        run_drive;
    logic        dir_drive;
    logic [7:0]  duty_out;
    logic [1:0]  motor_mode;
    logic        limit_hit;
  } out_item_t;

endpackage

>>> sv/limit_reversing_stepper_sequencer_core.sv
// Limit-reversing stepper sequencer: command decode, limit debounce and mode control.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One result per command, one command per cycle sustained while out_ready
// stays high. A command is captured in the input register, the
// mode/debounce/centering update runs in a single combinational pass from
// there, and the result lands in the output register: out_valid rises when
// the result is loaded there, after the command has sat in the input register.
// The output register lets a new command be taken while a result still
// waits; stalls back up through in_ready. cfg_ready is always high;
// registers should be written only while no command is in flight.
module limit_reversing_stepper_sequencer_core #(
  parameter int unsigned PWM_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lrss_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lrss_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);
  import lrss_pkg::*;

  localparam logic [7:0] DUTY_LIM = (PWM_BITS >= 8) ? 8'hFF : 8'((1 << PWM_BITS) - 1);

  // pipeline registers
  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r;
  logic      out_valid_r;

  // config
  logic [15:0] debounce_r;
  logic [15:0] extra_run_r;

  // sequencer state
  mode_t       mode_r, mode_nxt;
  logic        running_r, running_nxt;
  logic        dir_r, dir_nxt;
  logic        run_lvl_r, run_lvl_nxt;
  logic        last_sw_r, last_sw_nxt;
  logic [31:0] last_hit_r, last_hit_nxt;
  logic [31:0] center_r, center_nxt;
  logic [7:0]  duty_r, duty_nxt;

  logic        adv;
  logic        s1_fire;
  cmd_e_t      cmd;
  logic [31:0] hit_gap;
  logic [31:0] back_gap;
  logic        hit_cand;
  logic        back_live;
  logic        sample;
  logic        hit;

  assign adv       = !out_valid_r || out_ready;
  assign s1_fire   = in_valid_r && adv;
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign cmd       = cmd_e_t'(in_r.command);
  assign hit_gap   = in_r.now_ms - last_hit_r;
  assign back_gap  = in_r.now_ms - center_r;
  // falling edge with the debounce window elapsed
  assign hit_cand  = last_sw_r && !in_r.switch_level && (hit_gap > {16'b0, debounce_r});
  assign back_live = back_gap < {16'b0, extra_run_r};

  always_comb begin
    mode_nxt     = mode_r;
    running_nxt  = running_r;
    dir_nxt      = dir_r;
    run_lvl_nxt  = run_lvl_r;
    last_sw_nxt  = last_sw_r;
    last_hit_nxt = last_hit_r;
    center_nxt   = center_r;
    duty_nxt     = duty_r;
    sample       = 1'b0;
    unique case (cmd)
      CMD_UPDATE: begin
        unique case (mode_r)
          MODE_RUN, MODE_TO_LIMIT: sample = 1'b1;
          MODE_BACK: begin
            if (back_live) begin
              sample = 1'b1;
            end else begin
              mode_nxt    = MODE_IDLE;
              run_lvl_nxt = 1'b0;
              running_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      CMD_RUN: begin
        if (mode_r != MODE_RUN) begin
          mode_nxt    = MODE_RUN;
          running_nxt = 1'b1;
          run_lvl_nxt = 1'b1;
        end
        sample = 1'b1;
      end
      CMD_STOP: begin
        if (running_r) begin
          running_nxt = 1'b0;
          mode_nxt    = MODE_TO_LIMIT;
          run_lvl_nxt = 1'b1;
        end
      end
      default: begin
        duty_nxt = (in_r.duty_value > DUTY_LIM) ? DUTY_LIM : in_r.duty_value;
      end
    endcase
    hit = sample && hit_cand;
    if (sample) begin
      last_sw_nxt = in_r.switch_level;
    end
    if (hit) begin
      last_hit_nxt = in_r.now_ms;
      dir_nxt      = !dir_r;
      // reaching the limit while centering starts the run back
      if (cmd == CMD_UPDATE && mode_r == MODE_TO_LIMIT) begin
        mode_nxt   = MODE_BACK;
        center_nxt = in_r.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      running_r  <= 1'b0;
      dir_r      <= 1'b0;
      run_lvl_r  <= 1'b0;
      last_sw_r  <= 1'b1;
      last_hit_r <= '0;
      center_r   <= '0;
      duty_r     <= '0;
    end else if (s1_fire) begin
      mode_r     <= mode_nxt;
      running_r  <= running_nxt;
      dir_r      <= dir_nxt;
      run_lvl_r  <= run_lvl_nxt;
      last_sw_r  <= last_sw_nxt;
      last_hit_r <= last_hit_nxt;
      center_r   <= center_nxt;
      duty_r     <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      extra_run_r <= EXTRA_RUN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  debounce_r  <= cfg_data;
        REG_EXTRA_RUN: extra_run_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (s1_fire) begin
      out_r.run_drive  <= run_lvl_nxt;
      out_r.dir_drive  <= dir_nxt;
      out_r.duty_out   <= duty_nxt;
      out_r.motor_mode <= mode_nxt;
      out_r.limit_hit  <= hit;
    end
  end

  `LRSS_ASSERT(a_hit_not_idle, (out_valid_r && out_r.limit_hit) |-> (out_r.motor_mode != MODE_IDLE), "limit hit reported in idle")
  `LRSS_ASSERT_ALWAYS(a_drive_mode, rst_n |=> (run_lvl_r == (mode_r != MODE_IDLE)), "run level out of step with mode")
  `LRSS_ASSERT_ALWAYS(a_running_mode, rst_n |=> (running_r == (mode_r == MODE_RUN)), "running flag out of step with mode")
  `LRSS_ASSERT(a_duty_sat, duty_r <= DUTY_LIM, "duty above PWM limit")
  `LRSS_ASSERT(a_hit_stamp, (s1_fire && hit) |=> (last_hit_r == $past(in_r.now_ms)), "hit time not recorded")

endmodule
